/* hdl/lsi_pkg.sv */
// ----------------------------------------------------------------------------
// Line/sphere intersection package
// Shared constants, register indexes and the rounding helper of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

   // Default coordinate width (signed fixed point, Q16.16 at 32 bits).
   localparam int CoordBits = 32;

   // Direction components are normalized so the largest one has this many bits.
   localparam int NormBits = 30;

   // Root width of the direction length square root.
   localparam int LenBits = 32;

   // Working width of the rounding helper.
   localparam int WideBits = 128;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CsrCenterX = 2'd0,
      CsrCenterY = 2'd1,
      CsrCenterZ = 2'd2,
      CsrRadius  = 2'd3
   } csr_index_type;

   // Fraction bits of the unit direction for a given coordinate width.
   function automatic int unit_bits(input int coord_bits);
      return ((59 - coord_bits) < 30) ? (59 - coord_bits) : 30;
   endfunction

   // Divide by 2^s, rounding half away from zero.
   function automatic logic signed [WideBits-1:0] round_shift(
      input logic signed [WideBits-1:0] v,
      input int unsigned                 s
   );
      logic [WideBits-1:0] mag;
      logic [WideBits-1:0] res;
      mag = v[WideBits-1] ? WideBits'(-v) : WideBits'(v);
      res = (mag + (WideBits'(1) << (s - 1))) >> s;
      return v[WideBits-1] ? -$signed(res) : $signed(res);
   endfunction

endpackage

`default_nettype wire

/* hdl/lsi_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// Square root cell
// One bit of a digit-by-digit integer square root, registered, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_sqrt_cell #(
   parameter int RW = 32,
   parameter int SW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_n,
   input  logic [RW+1:0]     in_rem,
   input  logic [RW-1:0]     in_root,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [2*RW-1:0]   out_n,
   output logic [RW+1:0]     out_rem,
   output logic [RW-1:0]     out_root,
   output logic [SW-1:0]     out_side
);

   logic              valid_ff;
   logic [2*RW-1:0]   n_ff;
   logic [RW+1:0]     rem_ff;
   logic [RW-1:0]     root_ff;
   logic [SW-1:0]     side_ff;

   logic [RW+1:0]     rem_sh;
   logic [RW+1:0]     trial;
   logic              take;
   logic [2*RW-1:0]   n_in;
   logic [RW+1:0]     rem_in;
   logic [RW-1:0]     root_in;

   // Bring down the next pair of radicand bits and try the next root bit.
   always_comb begin
      rem_sh  = {in_rem[RW-1:0], in_n[2*RW-1:2*RW-2]};
      trial   = {in_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {in_root[RW-2:0], take};
      n_in    = in_n << 2;
   end

   // Valid bit of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload of this cell.
   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* hdl/lsi_div_cell.sv */
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of three restoring divisions sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_div_cell #(
   parameter int DRW = 32,
   parameter int QW  = 28,
   parameter int SW  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [2:0][DRW-1:0]   in_rem,
   input  logic [2:0][QW-1:0]    in_quo,
   input  logic [DRW-1:0]        in_div,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [2:0][DRW-1:0]   out_rem,
   output logic [2:0][QW-1:0]    out_quo,
   output logic [DRW-1:0]        out_div,
   output logic [SW-1:0]         out_side
);

   logic                  valid_ff;
   logic [2:0][DRW-1:0]   rem_ff;
   logic [2:0][QW-1:0]    quo_ff;
   logic [DRW-1:0]        div_ff;
   logic [SW-1:0]         side_ff;

   logic [2:0][DRW-1:0]   rem_in;
   logic [2:0][QW-1:0]    quo_in;
   logic [DRW-1:0]        diff;
   logic                  take;

   // Compare, subtract and shift each lane's partial remainder.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         take      = (in_rem[i] >= in_div);
         diff      = take ? (in_rem[i] - in_div) : in_rem[i];
         rem_in[i] = diff << 1;
         quo_in[i] = {in_quo[i][QW-2:0], take};
      end
   end

   // Valid bit of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload of this cell.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* hdl/line_sphere_intersection_core.sv */
// ----------------------------------------------------------------------------
// Line/sphere intersection core
// Nearest intersection of a line through two points with a sphere.
// ----------------------------------------------------------------------------
// Usage:
//  - Program the sphere center and radius through the csr_ write port while
//    no transaction is in flight. All registers reset to zero.
//  - Each req_ transaction carries points A and B of one line. Each one
//    yields exactly one rsp_ transaction: the hit flag and the nearer
//    intersection point, or zeros on a miss (also for A equal to B).
//  - Throughput is one transaction per cycle while the pipeline is not
//    stalled. The pipeline is a chain of one-bit square root and divider
//    cells: 32 cells for the direction length, unit_bits + 1 cells for the
//    unit vector and COORD_BITS - 1 cells for the half chord, plus sixteen
//    arithmetic stages and the output register.
//  - A synchronous reset empties the pipeline and the output register.
//  - When rsp_stall holds a result, the pipeline keeps taking transactions
//    until its last stage is full; then req_stall rises and all stages hold.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sphere_intersection_core #(
   parameter int COORD_BITS = lsi_pkg::CoordBits
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata,
   // Requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_start_z,
   input  logic signed [COORD_BITS-1:0]  req_toward_x,
   input  logic signed [COORD_BITS-1:0]  req_toward_y,
   input  logic signed [COORD_BITS-1:0]  req_toward_z,
   // Responses
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [COORD_BITS-1:0]  rsp_hit_x,
   output logic signed [COORD_BITS-1:0]  rsp_hit_y,
   output logic signed [COORD_BITS-1:0]  rsp_hit_z
);

   localparam int CB  = COORD_BITS;
   localparam int UB  = lsi_pkg::unit_bits(COORD_BITS);
   localparam int NB  = lsi_pkg::NormBits;
   localparam int LB  = lsi_pkg::LenBits;
   localparam int WB  = lsi_pkg::WideBits;
   localparam int DW  = CB + 1;
   localparam int BLW = $clog2(DW + 1);
   localparam int QW  = UB + 1;
   localparam int UW  = UB + 2;
   localparam int AW  = DW + UW + 2;
   localparam int TW  = CB + 4;
   localparam int PW  = UW + TW;
   localparam int HW  = CB - 1;

   localparam logic signed [TW:0] SatHi = {{(TW - CB + 2){1'b0}}, {(CB - 1){1'b1}}};
   localparam logic signed [TW:0] SatLo = {{(TW - CB + 2){1'b1}}, {(CB - 1){1'b0}}};

   // Sideband carried through the length square root chain.
   typedef struct packed {
      logic [2:0][CB-1:0] a;
      logic [2:0][DW-1:0] c;
      logic [2:0]         neg;
      logic               miss;
      logic [2:0][NB-1:0] dn;
   } len_side_type;

   // Sideband carried through the divider chain.
   typedef struct packed {
      logic [2:0][CB-1:0] a;
      logic [2:0][DW-1:0] c;
      logic [2:0]         neg;
      logic               miss;
   } div_side_type;

   // Sideband carried through the half chord square root chain.
   typedef struct packed {
      logic [2:0][CB-1:0] a;
      logic [2:0][UW-1:0] u;
      logic [TW-1:0]      t;
      logic               miss;
   } chord_side_type;

   localparam int LSW = $bits(len_side_type);
   localparam int DSW = $bits(div_side_type);
   localparam int CSW = $bits(chord_side_type);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [2:0][CB-1:0]  ctr_ff;
   logic [HW-1:0]       radius_ff;
   logic [2*HW-1:0]     r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff    <= '0;
         radius_ff <= '0;
      end else if (csr_write) begin
         unique case (lsi_pkg::csr_index_type'(csr_index))
            lsi_pkg::CsrCenterX: ctr_ff[0] <= csr_wdata;
            lsi_pkg::CsrCenterY: ctr_ff[1] <= csr_wdata;
            lsi_pkg::CsrCenterZ: ctr_ff[2] <= csr_wdata;
            lsi_pkg::CsrRadius:  radius_ff <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // Radius squared is registered from the radius register and follows it in the next cycle.
   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   // ------------------------------------------------------------------
   // Flow control: all stages move together unless a full last stage
   // faces a held response.
   // ------------------------------------------------------------------
   logic advance;
   logic out_load;
   logic s16_valid_ff;
   logic rsp_valid_ff;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = out_load || !s16_valid_ff;
   assign req_stall = !advance;

   // ------------------------------------------------------------------
   // Stage 1: direction B - A and center offset C - A
   // ------------------------------------------------------------------
   logic               s1_valid_ff;
   logic [2:0][CB-1:0] s1_a_ff;
   logic [2:0][DW-1:0] s1_d_ff;
   logic [2:0][DW-1:0] s1_c_ff;
   logic [2:0][CB-1:0] s1_a_in;
   logic [2:0][CB-1:0] s1_b_in;
   logic [2:0][DW-1:0] s1_d_in;
   logic [2:0][DW-1:0] s1_c_in;

   always_comb begin
      s1_a_in[0] = req_start_x;
      s1_a_in[1] = req_start_y;
      s1_a_in[2] = req_start_z;
      s1_b_in[0] = req_toward_x;
      s1_b_in[1] = req_toward_y;
      s1_b_in[2] = req_toward_z;
      for (int i = 0; i < 3; i++) begin
         s1_d_in[i] = DW'($signed(s1_b_in[i])) - DW'($signed(s1_a_in[i]));
         s1_c_in[i] = DW'($signed(ctr_ff[i])) - DW'($signed(s1_a_in[i]));
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: magnitudes and bit length of the largest component
   // ------------------------------------------------------------------
   logic               s2_valid_ff;
   logic [2:0][CB-1:0] s2_a_ff;
   logic [2:0][DW-1:0] s2_c_ff;
   logic [2:0][DW-1:0] s2_mag_ff;
   logic [2:0]         s2_neg_ff;
   logic [BLW-1:0]     s2_blen_ff;
   logic               s2_miss_ff;
   logic [2:0][DW-1:0] s2_mag_in;
   logic [2:0]         s2_neg_in;
   logic [DW-1:0]      s2_or;
   logic [BLW-1:0]     s2_blen_in;

   // The bit length of the largest magnitude is that of their bitwise OR.
   always_comb begin
      s2_or = '0;
      for (int i = 0; i < 3; i++) begin
         s2_neg_in[i] = s1_d_ff[i][DW-1];
         s2_mag_in[i] = s2_neg_in[i] ? (~s1_d_ff[i] + DW'(1)) : s1_d_ff[i];
         s2_or        = s2_or | s2_mag_in[i];
      end
      s2_blen_in = '0;
      for (int j = 0; j < DW; j++) begin
         if (s2_or[j]) begin
            s2_blen_in = BLW'(j + 1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: normalize so the largest component has NB bits
   // ------------------------------------------------------------------
   logic               s3_valid_ff;
   logic [2:0][CB-1:0] s3_a_ff;
   logic [2:0][DW-1:0] s3_c_ff;
   logic [2:0][NB-1:0] s3_dn_ff;
   logic [2:0]         s3_neg_ff;
   logic               s3_miss_ff;
   logic [2:0][NB-1:0] s3_dn_in;
   logic [DW+NB-1:0]   s3_shift;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_shift    = {s2_mag_ff[i], NB'(0)} >> s2_blen_ff;
         s3_dn_in[i] = s3_shift[NB-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: squares of the normalized components
   // ------------------------------------------------------------------
   logic                 s4_valid_ff;
   logic [2:0][CB-1:0]   s4_a_ff;
   logic [2:0][DW-1:0]   s4_c_ff;
   logic [2:0][NB-1:0]   s4_dn_ff;
   logic [2:0]           s4_neg_ff;
   logic                 s4_miss_ff;
   logic [2:0][2*NB-1:0] s4_sq_ff;

   // ------------------------------------------------------------------
   // Stage 5: sum of squares
   // ------------------------------------------------------------------
   logic                 s5_valid_ff;
   logic [2*LB-1:0]      s5_sum_ff;
   len_side_type         s5_side_ff;

   // Stages 1 to 5 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff    <= s1_a_in;
         s1_d_ff    <= s1_d_in;
         s1_c_ff    <= s1_c_in;

         s2_a_ff    <= s1_a_ff;
         s2_c_ff    <= s1_c_ff;
         s2_mag_ff  <= s2_mag_in;
         s2_neg_ff  <= s2_neg_in;
         s2_blen_ff <= s2_blen_in;
         s2_miss_ff <= (s2_or == '0);

         s3_a_ff    <= s2_a_ff;
         s3_c_ff    <= s2_c_ff;
         s3_dn_ff   <= s3_dn_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_miss_ff <= s2_miss_ff;

         s4_a_ff    <= s3_a_ff;
         s4_c_ff    <= s3_c_ff;
         s4_dn_ff   <= s3_dn_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_miss_ff <= s3_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= s3_dn_ff[i] * s3_dn_ff[i];
         end

         s5_sum_ff       <= (2*LB)'(s4_sq_ff[0]) + (2*LB)'(s4_sq_ff[1])
                            + (2*LB)'(s4_sq_ff[2]);
         s5_side_ff.a    <= s4_a_ff;
         s5_side_ff.c    <= s4_c_ff;
         s5_side_ff.neg  <= s4_neg_ff;
         s5_side_ff.miss <= s4_miss_ff;
         s5_side_ff.dn   <= s4_dn_ff;
      end
   end

   // ------------------------------------------------------------------
   // Length square root chain
   // ------------------------------------------------------------------
   logic [LB:0]                len_valid;
   logic [LB:0][2*LB-1:0]      len_n;
   logic [LB:0][LB+1:0]        len_rem;
   logic [LB:0][LB-1:0]        len_root;
   logic [LB:0][LSW-1:0]       len_side;

   assign len_valid[0] = s5_valid_ff;
   assign len_n[0]     = s5_sum_ff;
   assign len_rem[0]   = '0;
   assign len_root[0]  = '0;
   assign len_side[0]  = s5_side_ff;

   for (genvar k = 0; k < LB; k++) begin : g_len
      lsi_sqrt_cell #(
         .RW (LB),
         .SW (LSW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (len_valid[k]),
         .in_n      (len_n[k]),
         .in_rem    (len_rem[k]),
         .in_root   (len_root[k]),
         .in_side   (len_side[k]),
         .out_valid (len_valid[k+1]),
         .out_n     (len_n[k+1]),
         .out_rem   (len_rem[k+1]),
         .out_root  (len_root[k+1]),
         .out_side  (len_side[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Unit vector divider chain
   // ------------------------------------------------------------------
   len_side_type              len_out;
   div_side_type              div_in_side;
   logic [QW:0]               div_valid;
   logic [QW:0][2:0][LB-1:0]  div_rem;
   logic [QW:0][2:0][QW-1:0]  div_quo;
   logic [QW:0][LB-1:0]       div_div;
   logic [QW:0][DSW-1:0]      div_side;

   assign len_out          = len_side_type'(len_side[LB]);
   assign div_in_side.a    = len_out.a;
   assign div_in_side.c    = len_out.c;
   assign div_in_side.neg  = len_out.neg;
   assign div_in_side.miss = len_out.miss;

   assign div_valid[0] = len_valid[LB];
   assign div_div[0]   = len_root[LB];
   assign div_side[0]  = div_in_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_rem[0][i] = LB'(len_out.dn[i]);
         div_quo[0][i] = '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      lsi_div_cell #(
         .DRW (LB),
         .QW  (QW),
         .SW  (DSW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[k]),
         .in_rem    (div_rem[k]),
         .in_quo    (div_quo[k]),
         .in_div    (div_div[k]),
         .in_side   (div_side[k]),
         .out_valid (div_valid[k+1]),
         .out_rem   (div_rem[k+1]),
         .out_quo   (div_quo[k+1]),
         .out_div   (div_div[k+1]),
         .out_side  (div_side[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Stages 6 to 14: projection, distance to the line, chord test
   // ------------------------------------------------------------------
   div_side_type           div_out;
   assign div_out = div_side_type'(div_side[QW]);

   logic                   s6_valid_ff;
   logic [2:0][CB-1:0]     s6_a_ff;
   logic [2:0][DW-1:0]     s6_c_ff;
   logic [2:0][UW-1:0]     s6_u_ff;
   logic                   s6_miss_ff;

   logic                   s7_valid_ff;
   logic [2:0][CB-1:0]     s7_a_ff;
   logic [2:0][DW-1:0]     s7_c_ff;
   logic [2:0][UW-1:0]     s7_u_ff;
   logic [2:0][DW+UW-1:0]  s7_cu_ff;
   logic                   s7_miss_ff;

   logic                   s8_valid_ff;
   logic [2:0][CB-1:0]     s8_a_ff;
   logic [2:0][DW-1:0]     s8_c_ff;
   logic [2:0][UW-1:0]     s8_u_ff;
   logic signed [AW-1:0]   s8_acc_ff;
   logic                   s8_miss_ff;

   logic                   s9_valid_ff;
   logic [2:0][CB-1:0]     s9_a_ff;
   logic [2:0][DW-1:0]     s9_c_ff;
   logic [2:0][UW-1:0]     s9_u_ff;
   logic signed [TW-1:0]   s9_t_ff;
   logic                   s9_miss_ff;

   logic                   s10_valid_ff;
   logic [2:0][CB-1:0]     s10_a_ff;
   logic [2:0][DW-1:0]     s10_c_ff;
   logic [2:0][UW-1:0]     s10_u_ff;
   logic [2:0][PW-1:0]     s10_p_ff;
   logic signed [TW-1:0]   s10_t_ff;
   logic                   s10_miss_ff;

   logic                   s11_valid_ff;
   logic [2:0][CB-1:0]     s11_a_ff;
   logic [2:0][UW-1:0]     s11_u_ff;
   logic [2:0][HW-1:0]     s11_qm_ff;
   logic signed [TW-1:0]   s11_t_ff;
   logic                   s11_miss_ff;

   logic                   s12_valid_ff;
   logic [2:0][CB-1:0]     s12_a_ff;
   logic [2:0][UW-1:0]     s12_u_ff;
   logic [2:0][2*HW-1:0]   s12_qsq_ff;
   logic signed [TW-1:0]   s12_t_ff;
   logic                   s12_miss_ff;

   logic                   s13_valid_ff;
   logic [2:0][CB-1:0]     s13_a_ff;
   logic [2:0][UW-1:0]     s13_u_ff;
   logic [2*CB-1:0]        s13_d2_ff;
   logic signed [TW-1:0]   s13_t_ff;
   logic                   s13_miss_ff;

   logic                   s14_valid_ff;
   logic [2*HW-1:0]        s14_diff_ff;
   chord_side_type         s14_side_ff;

   logic [2:0][UW-1:0]     s6_u_in;
   logic signed [TW-1:0]   s9_t_in;
   logic [2:0][HW-1:0]     s11_qm_in;
   logic                   s11_far;
   logic signed [TW-1:0]   s11_q;
   logic [TW-1:0]          s11_qmag;
   logic                   s14_gt;

   // Signed unit vector components.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_u_in[i] = div_out.neg[i] ? (~UW'(div_quo[QW][i]) + UW'(1))
                                     : UW'(div_quo[QW][i]);
      end
   end

   // Projection of the center offset onto the line.
   assign s9_t_in = TW'(lsi_pkg::round_shift(WB'(s8_acc_ff), UB));

   // Offset from the center to the projected point, and the early miss test.
   always_comb begin
      s11_far = 1'b0;
      for (int i = 0; i < 3; i++) begin
         s11_q = TW'(lsi_pkg::round_shift(WB'($signed(s10_p_ff[i])), UB))
                 - TW'($signed(s10_c_ff[i]));
         s11_qmag     = s11_q[TW-1] ? TW'(-s11_q) : TW'(s11_q);
         s11_qm_in[i] = s11_qmag[HW-1:0];
         if (s11_qmag > TW'(radius_ff)) begin
            s11_far = 1'b1;
         end
      end
   end

   assign s14_gt = (s13_d2_ff > (2*CB)'(r2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
         s13_valid_ff <= 1'b0;
         s14_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff  <= div_valid[QW];
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
         s13_valid_ff <= s12_valid_ff;
         s14_valid_ff <= s13_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_a_ff     <= div_out.a;
         s6_c_ff     <= div_out.c;
         s6_u_ff     <= s6_u_in;
         s6_miss_ff  <= div_out.miss;

         s7_a_ff     <= s6_a_ff;
         s7_c_ff     <= s6_c_ff;
         s7_u_ff     <= s6_u_ff;
         s7_miss_ff  <= s6_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s7_cu_ff[i] <= (DW+UW)'($signed(s6_c_ff[i]) * $signed(s6_u_ff[i]));
         end

         s8_a_ff     <= s7_a_ff;
         s8_c_ff     <= s7_c_ff;
         s8_u_ff     <= s7_u_ff;
         s8_miss_ff  <= s7_miss_ff;
         s8_acc_ff   <= AW'($signed(s7_cu_ff[0])) + AW'($signed(s7_cu_ff[1]))
                        + AW'($signed(s7_cu_ff[2]));

         s9_a_ff     <= s8_a_ff;
         s9_c_ff     <= s8_c_ff;
         s9_u_ff     <= s8_u_ff;
         s9_t_ff     <= s9_t_in;
         s9_miss_ff  <= s8_miss_ff;

         s10_a_ff    <= s9_a_ff;
         s10_c_ff    <= s9_c_ff;
         s10_u_ff    <= s9_u_ff;
         s10_t_ff    <= s9_t_ff;
         s10_miss_ff <= s9_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s10_p_ff[i] <= PW'($signed(s9_u_ff[i]) * s9_t_ff);
         end

         s11_a_ff    <= s10_a_ff;
         s11_u_ff    <= s10_u_ff;
         s11_t_ff    <= s10_t_ff;
         s11_qm_ff   <= s11_qm_in;
         s11_miss_ff <= s10_miss_ff || s11_far;

         s12_a_ff    <= s11_a_ff;
         s12_u_ff    <= s11_u_ff;
         s12_t_ff    <= s11_t_ff;
         s12_miss_ff <= s11_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s12_qsq_ff[i] <= s11_qm_ff[i] * s11_qm_ff[i];
         end

         s13_a_ff    <= s12_a_ff;
         s13_u_ff    <= s12_u_ff;
         s13_t_ff    <= s12_t_ff;
         s13_miss_ff <= s12_miss_ff;
         s13_d2_ff   <= (2*CB)'(s12_qsq_ff[0]) + (2*CB)'(s12_qsq_ff[1])
                        + (2*CB)'(s12_qsq_ff[2]);

         s14_side_ff.a    <= s13_a_ff;
         s14_side_ff.u    <= s13_u_ff;
         s14_side_ff.t    <= s13_t_ff;
         s14_side_ff.miss <= s13_miss_ff || s14_gt;
         s14_diff_ff      <= (2*HW)'((2*CB)'(r2_ff) - s13_d2_ff);
      end
   end

   // ------------------------------------------------------------------
   // Half chord square root chain
   // ------------------------------------------------------------------
   logic [HW:0]              chd_valid;
   logic [HW:0][2*HW-1:0]    chd_n;
   logic [HW:0][HW+1:0]      chd_rem;
   logic [HW:0][HW-1:0]      chd_root;
   logic [HW:0][CSW-1:0]     chd_side;

   assign chd_valid[0] = s14_valid_ff;
   assign chd_n[0]     = s14_diff_ff;
   assign chd_rem[0]   = '0;
   assign chd_root[0]  = '0;
   assign chd_side[0]  = s14_side_ff;

   for (genvar k = 0; k < HW; k++) begin : g_chord
      lsi_sqrt_cell #(
         .RW (HW),
         .SW (CSW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chd_valid[k]),
         .in_n      (chd_n[k]),
         .in_rem    (chd_rem[k]),
         .in_root   (chd_root[k]),
         .in_side   (chd_side[k]),
         .out_valid (chd_valid[k+1]),
         .out_n     (chd_n[k+1]),
         .out_rem   (chd_rem[k+1]),
         .out_root  (chd_root[k+1]),
         .out_side  (chd_side[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Stages 15 and 16: line parameter of the hit and its offsets
   // ------------------------------------------------------------------
   chord_side_type         chd_out;
   assign chd_out = chord_side_type'(chd_side[HW]);

   logic                   s15_valid_ff;
   logic [2:0][CB-1:0]     s15_a_ff;
   logic [2:0][UW-1:0]     s15_u_ff;
   logic signed [TW-1:0]   s15_t0_ff;
   logic                   s15_miss_ff;

   logic [2:0][CB-1:0]     s16_a_ff;
   logic [2:0][PW-1:0]     s16_p_ff;
   logic                   s16_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s15_valid_ff <= 1'b0;
         s16_valid_ff <= 1'b0;
      end else if (advance) begin
         s15_valid_ff <= chd_valid[HW];
         s16_valid_ff <= s15_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s15_a_ff    <= chd_out.a;
         s15_u_ff    <= chd_out.u;
         s15_t0_ff   <= $signed(chd_out.t) - $signed(TW'(chd_root[HW]));
         s15_miss_ff <= chd_out.miss;

         s16_a_ff    <= s15_a_ff;
         s16_miss_ff <= s15_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s16_p_ff[i] <= PW'($signed(s15_u_ff[i]) * s15_t0_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register: hit point with saturation, zeros on a miss
   // ------------------------------------------------------------------
   logic                   rsp_hit_ff;
   logic [2:0][CB-1:0]     rsp_pt_ff;
   logic [2:0][CB-1:0]     out_pt;
   logic signed [TW:0]     out_sum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_sum = (TW+1)'($signed(s16_a_ff[i]))
                   + (TW+1)'(lsi_pkg::round_shift(WB'($signed(s16_p_ff[i])), UB));
         if (s16_miss_ff) begin
            out_pt[i] = '0;
         end else if (out_sum > SatHi) begin
            out_pt[i] = SatHi[CB-1:0];
         end else if (out_sum < SatLo) begin
            out_pt[i] = SatLo[CB-1:0];
         end else begin
            out_pt[i] = out_sum[CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s16_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hit_ff <= !s16_miss_ff;
         rsp_pt_ff  <= out_pt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_pt_ff[0];
   assign rsp_hit_y = rsp_pt_ff[1];
   assign rsp_hit_z = rsp_pt_ff[2];

endmodule

`default_nettype wire

/* hdl/lsi_checker.sv */
// ----------------------------------------------------------------------------
// Line/sphere intersection port checker
// Checks the top level's ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_checker #(
   parameter int COORD_BITS = lsi_pkg::CoordBits
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_hit,
   input wire logic signed [COORD_BITS-1:0]  rsp_hit_x,
   input wire logic signed [COORD_BITS-1:0]  rsp_hit_y,
   input wire logic signed [COORD_BITS-1:0]  rsp_hit_z
);

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Requests are held back only behind a stalled response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A miss carries a zero point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0))
      else $error("miss transaction with a nonzero point");

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_hit_x) && $stable(rsp_hit_y) && $stable(rsp_hit_z)))
      else $error("stalled response changed");

   // No response shows in the first cycle after reset is released.
   a_no_bypass: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset release");

endmodule

bind line_sphere_intersection_core lsi_checker #(
   .COORD_BITS (COORD_BITS)
) u_lsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_hit   (rsp_hit),
   .rsp_hit_x (rsp_hit_x),
   .rsp_hit_y (rsp_hit_y),
   .rsp_hit_z (rsp_hit_z)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line/sphere intersection core testbench
// Drives lines through directed and random transactions over several sphere
// settings. Each response is checked against a known answer on degenerate
// rows, else against a bit-exact software predictor of the fixed-point
// nearest-hit computation; both channels idle at random but for the last sphere.
// ----------------------------------------------------------------------------

module tb;

   localparam int UnitShift = 27;
   localparam int SettleCycles = 120;
   localparam int WatchdogLimit = 20000;

   typedef logic signed [31:0] coord_type;

   typedef struct {
      logic      hit;
      coord_type x;
      coord_type y;
      coord_type z;
   } hit_point_type;

   typedef struct {
      coord_type     ax, ay, az, bx, by, bz;
      logic          typed;
      hit_point_type want;
   } line_row_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   coord_type req_start_x, req_start_y, req_start_z;
   coord_type req_toward_x, req_toward_y, req_toward_z;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   coord_type rsp_hit_x, rsp_hit_y, rsp_hit_z;

   // Sphere as the predictor sees it.
   longint sphere_center [3];
   longint unsigned sphere_radius;

   hit_point_type pending_hits [$];
   int failures;
   int quiet_cycles;
   logic idling_on;
   int rsp_burst;

   line_sphere_intersection_core uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_start_z(req_start_z), .req_toward_x(req_toward_x),
      .req_toward_y(req_toward_y), .req_toward_z(req_toward_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_hit_z(rsp_hit_z)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Divide by 2^UnitShift, rounding half away from zero.
   function automatic longint round_unit(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (UnitShift - 1))) >> UnitShift;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return coord_type'(v);
   endfunction

   // Nearest intersection of line A->B with the programmed sphere.
   function automatic hit_point_type nearest_hit(coord_type a_in [3], coord_type b_in [3]);
      hit_point_type res;
      longint a [3], d [3], c [3], u [3], q [3];
      longint unsigned m, dm, sum, len, cand, um, d2, r2;
      logic [127:0] rest, hc, h;
      longint acc, t, t0;
      int blen;
      res = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
      m = 0;
      sum = 0;
      len = 0;
      acc = 0;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = a_in[i];
         d[i] = longint'(b_in[i]) - a[i];
         c[i] = sphere_center[i] - a[i];
         dm = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
         if (dm > m) m = dm;
      end
      if (m == 0) return res;
      blen = 0;
      while (blen < 64 && (m >> blen) != 0) blen++;
      for (int i = 0; i < 3; i++) begin
         dm = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
         dm = (blen > 30) ? (dm >> (blen - 30)) : (dm << (30 - blen));
         d[i] = (d[i] < 0) ? -longint'(dm) : longint'(dm);
         sum += dm * dm;
      end
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
         cand = len | (64'd1 << bit_i);
         if (cand * cand <= sum) len = cand;
      end
      for (int i = 0; i < 3; i++) begin
         dm = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
         um = (dm << UnitShift) / len;
         u[i] = (d[i] < 0) ? -longint'(um) : longint'(um);
         acc += c[i] * u[i];
      end
      t = round_unit(acc);
      for (int i = 0; i < 3; i++) begin
         q[i] = round_unit(u[i] * t) - c[i];
         dm = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
         if (dm > sphere_radius) return res;
         d2 += dm * dm;
      end
      r2 = sphere_radius * sphere_radius;
      if (d2 > r2) return res;
      // Half chord by a bitwise square root.
      rest = 128'(r2 - d2);
      h = '0;
      for (int bit_i = 63; bit_i >= 0; bit_i--) begin
         hc = h | (128'd1 << bit_i);
         if (hc * hc <= rest) h = hc;
      end
      t0 = t - longint'(h[63:0]);
      res.hit = 1'b1;
      res.x = clamp_coord(a[0] + round_unit(u[0] * t0));
      res.y = clamp_coord(a[1] + round_unit(u[1] * t0));
      res.z = clamp_coord(a[2] + round_unit(u[2] * t0));
      return res;
   endfunction

   task automatic write_csr(lsi_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         lsi_pkg::CsrCenterX: sphere_center[0] = longint'(signed'(value));
         lsi_pkg::CsrCenterY: sphere_center[1] = longint'(signed'(value));
         lsi_pkg::CsrCenterZ: sphere_center[2] = longint'(signed'(value));
         default: sphere_radius = value[30:0];
      endcase
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] r);
      write_csr(lsi_pkg::CsrCenterX, cx);
      write_csr(lsi_pkg::CsrCenterY, cy);
      write_csr(lsi_pkg::CsrCenterZ, cz);
      write_csr(lsi_pkg::CsrRadius, r);
   endtask

   // Wait until every response has arrived and the pipeline has drained.
   task automatic drain_pipeline();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Send one line; the expectation is queued when the transaction is taken.
   task automatic send_line(line_row_type row);
      coord_type a [3], b [3];
      if (idling_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_start_x <= row.ax;
      req_start_y <= row.ay;
      req_start_z <= row.az;
      req_toward_x <= row.bx;
      req_toward_y <= row.by;
      req_toward_z <= row.bz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      a = '{row.ax, row.ay, row.az};
      b = '{row.bx, row.by, row.bz};
      if (row.typed) pending_hits.push_back(row.want);
      else pending_hits.push_back(nearest_hit(a, b));
   endtask

   task automatic finish_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   // Random offset whose size spans many scales up to about 2^span.
   function automatic longint rand_offset(int span);
      longint v;
      v = longint'($urandom()) >> (32 - $urandom_range(1, (span > 32) ? 32 : span));
      return $urandom_range(0, 1) ? v : -v;
   endfunction

   // Mostly lines aimed near the sphere, some fully random.
   task automatic random_lines(int count);
      line_row_type row;
      int span;
      for (int n = 0; n < count; n++) begin
         row.typed = 1'b0;
         if ($urandom_range(0, 9) < 3) begin
            row.ax = rand_coord(); row.ay = rand_coord(); row.az = rand_coord();
            row.bx = rand_coord(); row.by = rand_coord(); row.bz = rand_coord();
            if ($urandom_range(0, 9) == 0) begin
               row.bx = row.ax; row.by = row.ay; row.bz = row.az;
            end
         end else begin
            span = 1;
            while ((64'd1 << span) < sphere_radius && span < 31) span++;
            row.ax = coord_type'(sphere_center[0] + rand_offset(span + 2));
            row.ay = coord_type'(sphere_center[1] + rand_offset(span + 2));
            row.az = coord_type'(sphere_center[2] + rand_offset(span + 2));
            row.bx = coord_type'(sphere_center[0] + rand_offset(span));
            row.by = coord_type'(sphere_center[1] + rand_offset(span));
            row.bz = coord_type'(sphere_center[2] + rand_offset(span));
         end
         send_line(row);
      end
   endtask

   // Response stall bursts.
   always @(negedge clock) begin
      if (!idling_on) begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
      end else if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker and watchdog.
   always @(posedge clock) begin
      hit_point_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_hit);
               failures++;
            end
            if (rsp_hit_x !== want.x) begin
               $error("hit_x: expected %0d actual %0d", want.x, rsp_hit_x);
               failures++;
            end
            if (rsp_hit_y !== want.y) begin
               $error("hit_y: expected %0d actual %0d", want.y, rsp_hit_y);
               failures++;
            end
            if (rsp_hit_z !== want.z) begin
               $error("hit_z: expected %0d actual %0d", want.z, rsp_hit_z);
               failures++;
            end
         end
      end
   end

   localparam coord_type Max = 32'sh7fffffff;
   localparam coord_type Min = 32'sh80000000;
   localparam coord_type One = 32'sh00010000;
   localparam hit_point_type Miss = '{1'b0, 32'sd0, 32'sd0, 32'sd0};

   // Directed lines; degenerate rows have a known answer.
   line_row_type directed [12] = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, Miss},
      '{Max, Max, Max, Max, Max, Max, 1'b1, Miss},
      '{Min, Min, Min, Min, Min, Min, 1'b1, Miss},
      '{Min, Min, Min, Max, Max, Max, 1'b0, Miss},
      '{Max, Max, Max, Min, Min, Min, 1'b0, Miss},
      '{Min, Max, Min, Max, Min, Max, 1'b0, Miss},
      '{-5 * One, 32'sd0, 32'sd0, 5 * One, 32'sd0, 32'sd0, 1'b0, Miss},
      '{32'sd0, -3 * One, 32'sd0, 32'sd0, One, 32'sd0, 1'b0, Miss},
      '{32'sd0, 32'sd0, 7 * One, 32'sd0, 32'sd0, 6 * One, 1'b0, Miss},
      '{-5 * One, One, 32'sd0, 5 * One, One, 32'sd0, 1'b0, Miss},
      '{32'sd0, 32'sd0, 32'sd0, One, One, One, 1'b0, Miss},
      '{Max, 32'sd0, 32'sd0, Max - 1, 32'sd0, 32'sd0, 1'b0, Miss}
   };

   initial begin
      failures = 0;
      quiet_cycles = 0;
      idling_on = 1'b1;
      rsp_burst = 0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = lsi_pkg::CsrCenterX;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_start_x = '0; req_start_y = '0; req_start_z = '0;
      req_toward_x = '0; req_toward_y = '0; req_toward_z = '0;
      sphere_center = '{0, 0, 0};
      sphere_radius = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines with the reset sphere, then with a unit sphere.
      foreach (directed[i]) send_line(directed[i]);
      finish_sending();
      drain_pipeline();
      set_sphere(32'd0, 32'd0, 32'd0, 32'h0001_0000);
      foreach (directed[i]) send_line(directed[i]);
      finish_sending();
      drain_pipeline();

      // Extreme spheres; the radius write carries a stray top bit.
      set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      random_lines(60);
      finish_sending();
      drain_pipeline();
      set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
      random_lines(40);
      finish_sending();
      drain_pipeline();

      // Random spheres of moderate size.
      for (int p = 0; p < 5; p++) begin
         set_sphere($urandom() >> 7, $urandom() >> 7, $urandom() >> 7,
                    $urandom_range(1 << 10, 1 << 26));
         if (p == 4) idling_on = 1'b0;
         random_lines(100);
         finish_sending();
         drain_pipeline();
      end

      if (failures == 0 && pending_hits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
